// ----- hdl/akvm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package akvm_pkg;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_ACCESS = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_HIT         = 2'd0;
  localparam logic [1:0] ST_MISS        = 2'd1;
  localparam logic [1:0] ST_DEL_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic shift;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic op_delete;
    logic hit;
    logic scan_end;
    logic shift_end;
    logic res_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/array_key_value_map.sv -----
// Key/value table kept as a packed array of up to CAPACITY entries and
// searched linearly from entry 0 upward.
// Input channel (in_valid/in_ready) carries one request word: command,
// key and write_value. Output channel (out_valid/out_ready) returns one
// result word per request: read_value, status and entry_count.
// A request is taken only while the block is idle. A lookup reads one
// entry per cycle from the key and value memories, stopping at the first
// matching entry, or after the last used entry on a miss. A delete that
// hits then moves each later entry down one place. The result sits in
// an output register; the next request is accepted while it waits, and
// only the final step of that next request stalls until the receiver
// takes the earlier result.
// Reset empties the table and drops any pending result; the memories
// themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module array_key_value_map
  import akvm_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         command,
  input  wire logic signed [31:0] key,
  input  wire logic [63:0]        write_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             read_value,
  output logic [1:0]              status,
  output logic [8:0]              entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  akvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  akvm_dp #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .key         (key),
    .write_value (write_value),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

// ----- hdl/akvm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module akvm_ctrl
  import akvm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_clear ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = stat.op_delete ? S_SHIFT : S_FINISH;
        end else if (stat.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.res_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = !stat.res_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/akvm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module akvm_dp
  import akvm_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [2:0]  command,
  input  wire logic signed [31:0] key,
  input  wire logic [63:0] write_value,
  output logic [63:0]      read_value,
  output logic [1:0]       status,
  output logic [8:0]       entry_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

  logic [2:0]             op;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] wv_r;
  logic [CW-1:0]          count;
  logic [CW-1:0]          ptr;
  logic                   pend;
  logic [AW-1:0]          tag;
  logic [KEY_WIDTH-1:0]   kq;
  logic [VALUE_WIDTH-1:0] vq;
  logic                   found;
  logic [AW-1:0]          pos;
  logic [VALUE_WIDTH-1:0] hitval;

  logic [KEY_WIDTH+31:0]   key_ext;
  logic [VALUE_WIDTH+63:0] wv_ext;
  logic [AW+CW-1:0]        tag_ext;
  logic [CW+8:0]           cnt_ext;
  logic [VALUE_WIDTH+63:0] rv_ext;

  logic                   rd_en;
  logic                   issue;
  logic                   hit;
  logic                   full;
  logic                   is_wr;
  logic                   is_ins;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [KEY_WIDTH-1:0]   wk;
  logic [VALUE_WIDTH-1:0] wval;
  logic [VALUE_WIDTH-1:0] rv_n;
  logic [1:0]             st_n;
  logic [CW-1:0]          cnt_n;

  assign key_ext = {{KEY_WIDTH{1'b0}}, key};
  assign wv_ext  = {{VALUE_WIDTH{1'b0}}, write_value};
  assign tag_ext = {{CW{1'b0}}, tag};

  assign issue = ptr < count;
  assign hit   = pend && (kq == key_r);
  assign full  = count == CW'(CAPACITY);
  assign is_wr = op == OP_WRITE;
  assign is_ins = (op == OP_ACCESS) || is_wr;
  assign rd_en = (cmd.scan && !hit && issue) || (cmd.shift && issue);

  assign stat.in_clear  = command == OP_CLEAR;
  assign stat.op_delete = op == OP_DELETE;
  assign stat.hit       = hit;
  assign stat.scan_end  = !pend && !issue;
  assign stat.shift_end = !pend && !issue;
  assign stat.res_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      kq <= key_mem[ptr[AW-1:0]];
      vq <= val_mem[ptr[AW-1:0]];
    end
    if (we) begin
      key_mem[wa] <= wk;
      val_mem[wa] <= wval;
    end
  end

  always_comb begin
    we   = 1'b0;
    wa   = tag - AW'(1);
    wk   = kq;
    wval = vq;
    if (cmd.shift && pend) begin
      we = 1'b1;
    end else if (cmd.finish && is_ins) begin
      if (found) begin
        we   = is_wr;
        wa   = pos;
        wk   = key_r;
        wval = wv_r;
      end else if (!full) begin
        we   = 1'b1;
        wa   = count[AW-1:0];
        wk   = key_r;
        wval = is_wr ? wv_r : '0;
      end
    end
  end

  always_comb begin
    rv_n  = '0;
    st_n  = ST_HIT;
    cnt_n = count;
    case (op)
      OP_CLEAR: begin
        cnt_n = '0;
      end
      OP_DELETE: begin
        if (found) begin
          cnt_n = count - CW'(1);
        end else begin
          st_n = ST_DEL_MISSING;
        end
      end
      OP_ACCESS, OP_WRITE: begin
        if (found) begin
          rv_n = is_wr ? wv_r : hitval;
        end else if (full) begin
          st_n = ST_FULL;
        end else begin
          rv_n  = is_wr ? wv_r : '0;
          st_n  = ST_MISS;
          cnt_n = count + CW'(1);
        end
      end
      default: begin
        if (found) begin
          rv_n = hitval;
        end else begin
          st_n = ST_MISS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op    <= command;
      key_r <= key_ext[KEY_WIDTH-1:0];
      wv_r  <= wv_ext[VALUE_WIDTH-1:0];
    end
    if (cmd.scan && hit) begin
      pos    <= tag;
      hitval <= vq;
    end
    if (rd_en) begin
      tag <= ptr[AW-1:0];
    end
    if (cmd.finish) begin
      rv_ext      <= {{64{1'b0}}, rv_n};
      status      <= st_n;
      cnt_ext     <= {9'd0, cnt_n};
    end
  end

  assign read_value  = rv_ext[63:0];
  assign entry_count = cnt_ext[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        ptr   <= '0;
        pend  <= 1'b0;
        found <= 1'b0;
      end else if (cmd.scan) begin
        if (hit) begin
          found <= 1'b1;
          pend  <= 1'b0;
          ptr   <= tag_ext[CW-1:0] + CW'(1);
        end else begin
          pend <= issue;
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
        end
      end else if (cmd.shift) begin
        pend <= issue;
        if (issue) begin
          ptr <= ptr + CW'(1);
        end
      end
      if (cmd.finish) begin
        count     <= cnt_n;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/map_checker.sv -----
`timescale 1ns / 1ps

module map_checker
  import akvm_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [31:0] key,
  input  logic [63:0]        write_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [63:0]        read_value,
  input  logic [1:0]         status,
  input  logic [8:0]         entry_count,
  output int                 errors,
  output int                 outstanding
);

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [8:0]  count;
  } map_result_t;

  map_result_t expected_results[$];
  logic [31:0] key_tbl[CAPACITY];
  logic [63:0] val_tbl[CAPACITY];
  int          used;

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < used; i++) begin
      if (key_tbl[i] == k) begin
        return i;
      end
    end
    return -1;
  endfunction

  task automatic serve_request(input logic [2:0] cmd, input logic [31:0] k,
                               input logic [63:0] wv, output map_result_t res);
    int pos;
    res.value  = '0;
    res.status = ST_HIT;
    pos = find_key(k);
    case (cmd)
      OP_CLEAR: begin
        used = 0;
      end
      OP_DELETE: begin
        if (pos >= 0) begin
          for (int j = pos; j + 1 < used; j++) begin
            key_tbl[j] = key_tbl[j + 1];
            val_tbl[j] = val_tbl[j + 1];
          end
          used--;
        end else begin
          res.status = ST_DEL_MISSING;
        end
      end
      OP_ACCESS, OP_WRITE: begin
        if (pos >= 0) begin
          if (cmd == OP_WRITE) begin
            val_tbl[pos] = wv;
          end
          res.value = val_tbl[pos];
        end else if (used >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          key_tbl[used] = k;
          val_tbl[used] = (cmd == OP_WRITE) ? wv : 64'd0;
          res.value     = val_tbl[used];
          res.status    = ST_MISS;
          used++;
        end
      end
      default: begin
        if (pos >= 0) begin
          res.value = val_tbl[pos];
        end else begin
          res.status = ST_MISS;
        end
      end
    endcase
    res.count = 9'(used);
  endtask

  always @(posedge clk) begin
    map_result_t want;
    map_result_t next_result;
    if (rst) begin
      used = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected: value %h, status %0d, count %0d",
                   $time, read_value, status, entry_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (read_value !== want.value) begin
            $display("%0t: read_value expected %h, actual %h", $time, want.value, read_value);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
            errors++;
          end
          if (entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d, actual %0d",
                     $time, want.count, entry_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        serve_request(command, key, write_value, next_result);
        expected_results.push_back(next_result);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import akvm_pkg::*;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = OP_READ;
  logic [31:0] key = '0;
  logic [63:0] write_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] read_value;
  logic [1:0]  status;
  logic [8:0]  entry_count;
  int          errors;
  int          outstanding;

  bit          tx_quiet;
  bit          rx_quiet;
  int          words_sent;
  int          rx_stall_left;
  int          rx_cycles;
  logic [31:0] key_pool[16];
  logic [31:0] fill_keys[300];

  array_key_value_map u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .key         (key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

  map_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .key         (key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [63:0] rand64();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      return OP_READ;
    end else if (r < 44) begin
      return OP_ACCESS;
    end else if (r < 70) begin
      return OP_WRITE;
    end else if (r < 92) begin
      return OP_DELETE;
    end else if (r < 95) begin
      return OP_CLEAR;
    end
    case ($urandom_range(0, 2))
      0: return OP_RSVD5;
      1: return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 70) begin
      return key_pool[$urandom_range(0, 15)];
    end
    return $urandom;
  endfunction

  // The receiver stalls at random, with quiet stretches where it never stalls.
  always @(posedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles % 300 == 0) begin
      rx_quiet <= ($urandom_range(0, 3) == 0);
    end
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_quiet && $urandom_range(0, 99) < 25) begin
        rx_stall_left <= gap_len();
      end
    end
  end

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input logic [2:0] cmd, input logic [31:0] k,
                           input logic [63:0] wv);
    int  gap;
    bit  taken;
    gap = tx_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    key         <= k;
    write_value <= wv;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    words_sent++;
    if (words_sent % 50 == 0) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int j;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < 16; i++) begin
      key_pool[i] = (i < 8) ? 32'($urandom_range(1, 20)) : $urandom;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_READ, 32'h0000_0000, 64'd0);
    send_word(OP_DELETE, 32'h0000_0005, 64'd0);
    send_word(OP_ACCESS, 32'h7fff_ffff, '1);
    send_word(OP_WRITE, 32'h8000_0000, '1);
    send_word(OP_WRITE, 32'hffff_ffff, 64'd0);
    send_word(OP_WRITE, 32'h8000_0000, 64'h0123_4567_89ab_cdef);
    send_word(OP_READ, 32'h8000_0000, 64'd0);
    send_word(OP_ACCESS, 32'h7fff_ffff, 64'h1);
    send_word(OP_READ, 32'h0000_3039, 64'd0);
    send_word(OP_RSVD5, 32'hffff_ffff, '1);
    send_word(OP_RSVD6, 32'h0000_0000, '1);
    send_word(OP_RSVD7, 32'h8000_0000, 64'd0);
    send_word(OP_DELETE, 32'h7fff_ffff, 64'd0);
    send_word(OP_DELETE, 32'h7fff_ffff, 64'd0);
    send_word(OP_READ, 32'hffff_ffff, 64'd0);
    send_word(OP_WRITE, 32'h0000_0000, 64'h8000_0000_0000_0001);
    send_word(OP_DELETE, 32'hffff_ffff, 64'd0);
    send_word(OP_DELETE, 32'h0000_0000, 64'd0);
    send_word(OP_CLEAR, 32'h0000_0000, 64'd0);
    send_word(OP_READ, 32'h8000_0000, 64'd0);
    send_word(OP_CLEAR, 32'hffff_ffff, '1);
    send_word(OP_WRITE, 32'h0000_0001, 64'h5555_5555_5555_5555);
    send_word(OP_WRITE, 32'h0000_0002, 64'haaaa_aaaa_aaaa_aaaa);

    // Fill past capacity with distinct keys, so the last inserts are refused.
    for (int i = 0; i < 300; i++) begin
      fill_keys[i] = {9'(i) ^ 9'h0a5, 23'($urandom)};
      send_word($urandom_range(0, 1) ? OP_WRITE : OP_ACCESS, fill_keys[i], rand64());
      if ($urandom_range(0, 9) == 0) begin
        send_word(OP_READ, fill_keys[$urandom_range(0, i)], rand64());
      end
    end

    // Churn around the full mark: deletes free slots that writes then take.
    repeat (60) begin
      j = $urandom_range(0, 299);
      case ($urandom_range(0, 2))
        0: send_word(OP_DELETE, fill_keys[j], rand64());
        1: send_word(OP_WRITE, fill_keys[j], rand64());
        default: send_word(OP_ACCESS, fill_keys[j], rand64());
      endcase
    end
    send_word(OP_CLEAR, $urandom, rand64());

    repeat (760) begin
      send_word(pick_command(), pick_key(), rand64());
    end

    in_valid <= 1'b0;
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
